// ----- src/stt_pkg.sv -----
// Shared types and constants for the sample trim table.
// Used by the controller, the datapath, the top level and the port checker.
package stt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int KEY_W             = 8;
  localparam int FRAME_W           = 32;
  localparam int COUNT_OUT_W       = 6;

  // request opcodes
  localparam logic CMD_SET    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTHING  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RLAST,
    S_MOVE,
    S_DONE
  } state_t;

  // one stored trim record
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [FRAME_W-1:0] start_fr;
    logic [FRAME_W-1:0] end_fr;
    logic               lp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    search;
    logic    hit_save;
    logic    read_last;
    logic    wr_update;
    logic    wr_append;
    logic    wr_move;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    logic    found_load;
    logic    out_load;
    status_t code;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic lookup;
    logic remove;
    logic full;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- src/stt_ctrl.sv -----
// Sequencer for the sample trim table: search, remove move, result hand-off.
// Depends on stt_pkg.
module stt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stt_pkg::dp_stat_t stat,
  output stt_pkg::ctl_cmd_t ctl
);
  import stt_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.hit && !stat.lookup && stat.remove) state_next = S_RLAST;
        else if (stat.hit || stat.miss) state_next = S_DONE;
      end
      S_RLAST: state_next = S_MOVE;
      S_MOVE:  state_next = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl      = '0;
    ctl.code = ST_NOTHING;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_SEARCH: begin
        ctl.search = 1'b1;
        if (stat.hit) begin
          ctl.hit_save   = 1'b1;
          ctl.set_status = 1'b1;
          if (stat.lookup) begin
            ctl.found_load = 1'b1;
            ctl.code       = ST_NOTHING;
          end else if (stat.remove) begin
            ctl.code = ST_REMOVED;
          end else begin
            ctl.wr_update = 1'b1;
            ctl.code      = ST_UPDATED;
          end
        end else if (stat.miss) begin
          ctl.set_status = 1'b1;
          if (stat.lookup || stat.remove) begin
            ctl.code = ST_NOTHING;
          end else if (stat.full) begin
            ctl.code = ST_FULL;
          end else begin
            ctl.wr_append = 1'b1;
            ctl.cnt_inc   = 1'b1;
            ctl.code      = ST_INSERTED;
          end
        end
      end
      S_RLAST: ctl.read_last = 1'b1;
      S_MOVE: begin
        ctl.wr_move = 1'b1;
        ctl.cnt_dec = 1'b1;
      end
      S_DONE: ctl.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- src/stt_datapath.sv -----
// Datapath of the sample trim table: request latch, entry memory, scan
// pointers, entry count and the output register. Depends on stt_pkg.
module stt_datapath #(
  parameter int TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  stt_pkg::ctl_cmd_t                  ctl,
  output stt_pkg::dp_stat_t                  stat,
  input  logic                               cmd,
  input  logic [stt_pkg::KEY_W-1:0]          sample_id,
  input  logic [stt_pkg::FRAME_W-1:0]        start_frame,
  input  logic [stt_pkg::FRAME_W-1:0]        end_frame,
  input  logic                               loop_flag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status,
  output logic                               found,
  output logic [stt_pkg::FRAME_W-1:0]        found_start,
  output logic [stt_pkg::FRAME_W-1:0]        found_end,
  output logic                               found_loop,
  output logic [stt_pkg::COUNT_OUT_W-1:0]    entry_count
);
  import stt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // latched request
  logic               req_cmd;
  logic [KEY_W-1:0]   req_key;
  logic [FRAME_W-1:0] req_start;
  logic [FRAME_W-1:0] req_end;
  logic               req_loop;

  // table state and scan
  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_data;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_m1;
  logic [CNT_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cmp_ptr;
  logic               cmp_vld;
  logic [IDX_W-1:0]   hit_idx;

  // staged result
  status_t            stat_q;
  logic               fnd_q;
  logic [FRAME_W-1:0] fs_q;
  logic [FRAME_W-1:0] fe_q;
  logic               fl_q;

  logic               more;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               key_eq;

  assign count_m1 = count - 1'b1;
  assign more     = (rd_ptr < count);
  assign key_eq   = (rd_data.key == req_key);

  // status to controller
  assign stat.hit      = cmp_vld && key_eq;
  assign stat.miss     = !(cmp_vld && key_eq) &&
                         (cmp_vld ? (cmp_ptr == count_m1) : !more);
  assign stat.lookup   = (req_cmd == CMD_LOOKUP);
  assign stat.remove   = (req_start == '0) && (req_end == '0) && !req_loop;
  assign stat.full     = (count == CNT_W'(TABLE_ENTRIES));
  assign stat.out_busy = out_valid && !out_ready;

  // request latch
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_cmd   <= cmd;
      req_key   <= sample_id;
      req_start <= start_frame;
      req_end   <= end_frame;
      req_loop  <= loop_flag;
    end
  end

  // scan pointers: issue one read per cycle, compare the previous one
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else if (ctl.accept) begin
      rd_ptr  <= '0;
      cmp_vld <= 1'b0;
    end else if (ctl.search) begin
      cmp_vld <= more;
      if (more) begin
        rd_ptr  <= rd_ptr + 1'b1;
        cmp_ptr <= rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit_save) hit_idx <= cmp_ptr[IDX_W-1:0];
  end

  // memory port selection
  assign rd_en   = (ctl.search && more) || ctl.read_last;
  assign rd_addr = ctl.read_last ? count_m1[IDX_W-1:0] : rd_ptr[IDX_W-1:0];
  assign wr_en   = ctl.wr_update || ctl.wr_append || ctl.wr_move;

  always_comb begin
    wr_addr = hit_idx;
    wr_data = rd_data;
    if (ctl.wr_update) begin
      wr_addr = cmp_ptr[IDX_W-1:0];
    end else if (ctl.wr_append) begin
      wr_addr = count[IDX_W-1:0];
    end
    if (!ctl.wr_move) begin
      wr_data = '{key: req_key, start_fr: req_start, end_fr: req_end, lp: req_loop};
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + 1'b1;
    end else if (ctl.cnt_dec) begin
      count <= count_m1;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (ctl.set_status) begin
      stat_q <= ctl.code;
      fnd_q  <= ctl.found_load;
      fs_q   <= ctl.found_load ? rd_data.start_fr : '0;
      fe_q   <= ctl.found_load ? rd_data.end_fr : '0;
      fl_q   <= ctl.found_load && rd_data.lp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status      <= stat_q;
      found       <= fnd_q;
      found_start <= fs_q;
      found_end   <= fe_q;
      found_loop  <= fl_q;
      entry_count <= COUNT_OUT_W'(count);
    end
  end

endmodule

// ----- src/sample_trim_table_top.sv -----
// Top level of the sample trim table: controller plus datapath.
// Depends on stt_pkg, stt_ctrl and stt_datapath.
//
//  channel  | signals               | payload
//  ---------+-----------------------+------------------------------------------
//  request  | in_valid / in_ready   | cmd, sample_id, start_frame, end_frame,
//           |                       | loop_flag
//  result   | out_valid / out_ready | status, found, found_start, found_end,
//           |                       | found_loop, entry_count
//
// One request at a time. The scan reads one entry per cycle from the entry
// memory, so the time from a request's accept to the next accept grows with n,
// n being the entries scanned up to the match, or all valid entries on a miss
// (up to TABLE_ENTRIES); a remove then fetches the last entry (S_RLAST) and
// moves it into the hole (S_MOVE). A result waits in the output register;
// the next request is taken while it waits, and the block only stalls before
// handing over the following result. rst clears the count and the handshakes;
// the entry memory needs no clearing.
module sample_trim_table_top #(
  parameter int TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [stt_pkg::KEY_W-1:0]          sample_id,
  input  logic [stt_pkg::FRAME_W-1:0]        start_frame,
  input  logic [stt_pkg::FRAME_W-1:0]        end_frame,
  input  logic                               loop_flag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status,
  output logic                               found,
  output logic [stt_pkg::FRAME_W-1:0]        found_start,
  output logic [stt_pkg::FRAME_W-1:0]        found_end,
  output logic                               found_loop,
  output logic [stt_pkg::COUNT_OUT_W-1:0]    entry_count
);
  import stt_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // sequencer
  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // table and result path
  stt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .sample_id   (sample_id),
    .start_frame (start_frame),
    .end_frame   (end_frame),
    .loop_flag   (loop_flag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .found_start (found_start),
    .found_end   (found_end),
    .found_loop  (found_loop),
    .entry_count (entry_count)
  );

endmodule

// ----- src/stt_check.sv -----
// Port-level checker for the sample trim table and its bind to the top level.
// Depends on stt_pkg.
module stt_check #(
  parameter int TABLE_ENTRIES = stt_pkg::TABLE_ENTRIES_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               cmd,
  input logic [stt_pkg::KEY_W-1:0]          sample_id,
  input logic [stt_pkg::FRAME_W-1:0]        start_frame,
  input logic [stt_pkg::FRAME_W-1:0]        end_frame,
  input logic                               loop_flag,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [2:0]                         status,
  input logic                               found,
  input logic [stt_pkg::FRAME_W-1:0]        found_start,
  input logic [stt_pkg::FRAME_W-1:0]        found_end,
  input logic                               found_loop,
  input logic [stt_pkg::COUNT_OUT_W-1:0]    entry_count
);
  import stt_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found) &&
      $stable(found_start) && $stable(found_end) && $stable(entry_count))
    else $error("result changed while stalled");

  // a pending request is not dropped by the requester
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(sample_id) && $stable(cmd))
    else $error("request withdrawn before accept");

  // only a successful lookup reports found, and it changes nothing
  a_found_nothing: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_NOTHING)
    else $error("found set on a result that changed the table");

  // no found entry means zeroed trim fields
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> found_start == '0 && found_end == '0 && !found_loop)
    else $error("trim fields nonzero without a found entry");

  // count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (TABLE_ENTRIES > 63) || (int'(entry_count) <= TABLE_ENTRIES))
    else $error("entry count beyond table size");

endmodule

bind sample_trim_table_top stt_check #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_stt_check (.*);

// ----- verif/tb_sample_trim_table_top.sv -----
// Self-checking testbench for sample_trim_table_top: directed and random trim requests.
// Depends on stt_pkg and the sample_trim_table_top RTL; keeps a shadow copy of the table.
module tb_sample_trim_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int ENTRIES        = TABLE_ENTRIES_DEF;
  localparam int RESET_CYCLES   = 4;
  localparam int SEGMENTS       = 20;
  localparam int SEG_ITEMS      = 100;
  localparam int HOLD_AT        = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_WIDE} mix_t;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   id;
    logic [FRAME_W-1:0] sf;
    logic [FRAME_W-1:0] ef;
    logic               lp;
  } trim_req_t;

  typedef struct packed {
    status_t                  status;
    logic                     found;
    logic [FRAME_W-1:0]       f_start;
    logic [FRAME_W-1:0]       f_end;
    logic                     f_loop;
    logic [COUNT_OUT_W-1:0]   count;
  } trim_result_t;

  // Shadow of the trim table plus the results it owes
  class trim_table_mirror;
    logic [KEY_W-1:0]   keys   [ENTRIES];
    logic [FRAME_W-1:0] starts [ENTRIES];
    logic [FRAME_W-1:0] ends   [ENTRIES];
    logic               loops  [ENTRIES];
    int                 count;
    trim_result_t       due_results[$];
    int                 mismatches;

    function void take_request(trim_req_t q);
      trim_result_t r;
      int           hit;
      logic         wipe;
      r        = '0;
      r.status = ST_NOTHING;
      hit      = -1;
      // scan backward so the first matching slot wins
      for (int i = count - 1; i >= 0; i--)
        if (keys[i] == q.id) hit = i;

      if (q.op == CMD_LOOKUP) begin
        if (hit >= 0) begin
          r.found   = 1'b1;
          r.f_start = starts[hit];
          r.f_end   = ends[hit];
          r.f_loop  = loops[hit];
        end
      end else begin
        wipe = (q.sf == '0) && (q.ef == '0) && !q.lp;
        if (hit >= 0 && wipe) begin
          // last entry fills the hole (may be the same slot)
          keys[hit]   = keys[count-1];
          starts[hit] = starts[count-1];
          ends[hit]   = ends[count-1];
          loops[hit]  = loops[count-1];
          count--;
          r.status = ST_REMOVED;
        end else if (hit >= 0) begin
          starts[hit] = q.sf;
          ends[hit]   = q.ef;
          loops[hit]  = q.lp;
          r.status    = ST_UPDATED;
        end else if (wipe) begin
          r.status = ST_NOTHING;
        end else if (count >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          keys[count]   = q.id;
          starts[count] = q.sf;
          ends[count]   = q.ef;
          loops[count]  = q.lp;
          count++;
          r.status = ST_INSERTED;
        end
      end
      r.count = COUNT_OUT_W'(count);
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [FRAME_W-1:0] want, logic [FRAME_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(logic [2:0] st, logic fnd, logic [FRAME_W-1:0] fs,
                               logic [FRAME_W-1:0] fe, logic fl,
                               logic [COUNT_OUT_W-1:0] cnt);
      trim_result_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: status %0d, entry_count %0d", st, cnt);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("status", FRAME_W'(want.status), FRAME_W'(st));
      compare("found", FRAME_W'(want.found), FRAME_W'(fnd));
      compare("found_start", want.f_start, fs);
      compare("found_end", want.f_end, fe);
      compare("found_loop", FRAME_W'(want.f_loop), FRAME_W'(fl));
      compare("entry_count", FRAME_W'(want.count), FRAME_W'(cnt));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   cmd = CMD_SET;
  logic [KEY_W-1:0]       sample_id = '0;
  logic [FRAME_W-1:0]     start_frame = '0;
  logic [FRAME_W-1:0]     end_frame = '0;
  logic                   loop_flag = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             status;
  logic                   found;
  logic [FRAME_W-1:0]     found_start;
  logic [FRAME_W-1:0]     found_end;
  logic                   found_loop;
  logic [COUNT_OUT_W-1:0] entry_count;

  trim_table_mirror mirror;
  int               stall_cycles = 0;
  bit               gaps_on = 1'b1;

  sample_trim_table_top #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return FRAME_W'($urandom_range(0, 1000));
    return $urandom;
  endfunction

  // Random request; keys mostly come from a 40-wide window so the table fills
  function automatic trim_req_t make_request(mix_t mix, logic [KEY_W-1:0] base);
    trim_req_t q;
    int        r;
    int        lookup_pct;
    int        remove_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        lookup_pct = 20;
        remove_pct = 30;
      end
      MIX_DRAIN: begin
        lookup_pct = 25;
        remove_pct = 70;
      end
      default: begin
        lookup_pct = 30;
        remove_pct = 45;
      end
    endcase
    q.id = (mix == MIX_WIDE) ? KEY_W'($urandom_range(0, 255))
                             : base + KEY_W'($urandom_range(0, 39));
    if (r < lookup_pct) begin
      // frame fields are don't-care on lookup; fill them anyway
      q.op = CMD_LOOKUP;
      q.sf = $urandom;
      q.ef = $urandom;
      q.lp = 1'($urandom_range(0, 1));
    end else if (r < remove_pct) begin
      q.op = CMD_SET;
      q.sf = '0;
      q.ef = '0;
      q.lp = 1'b0;
    end else begin
      q.op = CMD_SET;
      q.sf = pick_frame();
      q.ef = pick_frame();
      q.lp = 1'($urandom_range(0, 1));
    end
    return q;
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input trim_req_t q);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= q.op;
    sample_id   <= q.id;
    start_frame <= q.sf;
    end_frame   <= q.ef;
    loop_flag   <= q.lp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering until every owed result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (mirror.due_results.size() != 0);
    @(posedge clk);
  endtask

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        mirror.match_result(status, found, found_start, found_end, found_loop, entry_count);
      if (in_valid && in_ready)
        mirror.take_request('{cmd, sample_id, start_frame, end_frame, loop_flag});
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Result side: random stalls, ready bursts, and one long hold-off
  initial begin
    int cyc;
    int n;
    bit held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      if (!held && cyc >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        cyc += LONG_HOLD;
        held = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = pick_gap() + 1;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        cyc += n;
      end else begin
        n = $urandom_range(1, 40);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
        cyc += n;
      end
    end
  end

  // Watchdog on cycles with no handshake
  initial begin
    do @(negedge clk); while (stall_cycles < WATCHDOG_LIMIT);
    $display("FAIL sample_trim_table_top");
    $finish;
  end

  // Main sequence
  initial begin
    mix_t             mix;
    logic [KEY_W-1:0] base;
    mirror = new();
    base   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // lookup and remove on an empty table
    send_request(trim_req_t'{CMD_LOOKUP, 8'd5, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_SET, 8'd5, 32'd0, 32'd0, 1'b0});
    // loop bit alone is not a remove
    send_request(trim_req_t'{CMD_SET, 8'd5, 32'd0, 32'd0, 1'b1});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd5, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_SET, 8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd5, 32'd0, 32'd0, 1'b0});
    // remove the only entry: last moves onto itself
    send_request(trim_req_t'{CMD_SET, 8'd5, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd5, 32'd0, 32'd0, 1'b0});
    // key extremes, then remove from slot 0 so the last entry moves down
    send_request(trim_req_t'{CMD_SET, 8'd0, 32'd1, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_SET, 8'd255, 32'd0, 32'd1, 1'b0});
    send_request(trim_req_t'{CMD_SET, 8'd128, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1});
    send_request(trim_req_t'{CMD_SET, 8'd0, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd128, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd255, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd0, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_SET, 8'd255, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_SET, 8'd128, 32'd0, 32'd0, 1'b0});
    send_request(trim_req_t'{CMD_LOOKUP, 8'd128, 32'd0, 32'd0, 1'b0});
    drain();

    // random segments: fill to full, drain, wide keys
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 2) drain();
      if (seg % 2 == 0) base = KEY_W'($urandom_range(0, 255));
      case (seg % 4)
        0, 2:    mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_WIDE;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < SEG_ITEMS; k++)
        send_request(make_request(mix, base));
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mirror.due_results.size() != 0) begin
      $error("%0d results never arrived", mirror.due_results.size());
      mirror.mismatches++;
    end
    if (mirror.mismatches == 0)
      $display("PASS sample_trim_table_top");
    else
      $display("FAIL sample_trim_table_top");
    $finish;
  end

endmodule
